>>> hdl/pnoise_pkg.sv
// Shared types, constants and the Tausworthe step for the pink noise generator.
// No dependencies; every other file imports this package.
`default_nettype none

package pnoise_pkg;

    localparam int TAUS_W    = 32;
    localparam int DIE_W     = 19;
    localparam int DIE_SHIFT = 13;
    localparam int TOTAL_W   = 23;
    localparam int SAMPLE_W  = 24;
    localparam int ROWS_DEF  = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [TAUS_W-1:0] SEED_FIRST_RST  = 32'd12345;
    localparam logic [TAUS_W-1:0] SEED_SECOND_RST = 32'd67890;
    localparam logic [TAUS_W-1:0] SEED_THIRD_RST  = 32'd13579;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_THIRD  = 2'd2;

    // 2^22 and 3 * 2^22 for the Q2.22 mapping
    localparam logic [SAMPLE_W-1:0] Q_HALF  = 24'h400000;
    localparam logic [SAMPLE_W-1:0] Q_THREE = 24'hC00000;

    typedef struct packed {
        logic [TAUS_W-1:0] a;
        logic [TAUS_W-1:0] b;
        logic [TAUS_W-1:0] c;
    } t_taus;

    typedef struct packed {
        logic busy;   // fill engine running or pending, hold off input
        logic load;   // copy the prepared set into the live state
    } t_fill_stat;

    // One step of the three-component combined Tausworthe generator
    function automatic t_taus taus_next(input t_taus s);
        logic [TAUS_W-1:0] t;
        t_taus n;
        t   = ((s.a << 13) ^ s.a) >> 19;
        n.a = ((s.a & 32'hFFFF_FFFE) << 12) ^ t;
        t   = ((s.b << 2) ^ s.b) >> 25;
        n.b = ((s.b & 32'hFFFF_FFF8) << 4) ^ t;
        t   = ((s.c << 3) ^ s.c) >> 11;
        n.c = ((s.c & 32'hFFFF_FFF0) << 17) ^ t;
        return n;
    endfunction

    function automatic logic [TAUS_W-1:0] taus_out(input t_taus s);
        return s.a ^ s.b ^ s.c;
    endfunction

endpackage

`default_nettype wire

>>> hdl/pnoise_fill.sv
// Seed registers and the dice fill engine: one Tausworthe draw per cycle.
// Depends on pnoise_pkg.
`default_nettype none

module pnoise_fill
    import pnoise_pkg::*;
#(
    parameter int NUM_ROWS = ROWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TAUS_W-1:0]    i_cfg_data,
    output t_fill_stat           o_stat,
    output t_taus                o_prep_taus,
    output logic [DIE_W-1:0]     o_prep_dice [NUM_ROWS],
    output logic [TOTAL_W-1:0]   o_prep_total
);

    localparam int IDX_W = $clog2(NUM_ROWS);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_ROWS - 1);

    logic [TAUS_W-1:0]  r_seed_first;
    logic [TAUS_W-1:0]  r_seed_second;
    logic [TAUS_W-1:0]  r_seed_third;
    logic               r_busy;
    logic               r_dirty;
    logic               r_init;
    logic               r_load;
    logic [IDX_W-1:0]   r_cnt;
    t_taus              r_work;
    logic [DIE_W-1:0]   r_dice [NUM_ROWS];
    logic [TOTAL_W-1:0] r_total;

    t_taus              n_work;
    logic [TAUS_W-1:0]  w_draw;
    logic [DIE_W-1:0]   n_die;

    assign n_work = taus_next(r_work);
    assign w_draw = taus_out(n_work);
    assign n_die  = w_draw[TAUS_W-1:DIE_SHIFT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_first  <= SEED_FIRST_RST;
            r_seed_second <= SEED_SECOND_RST;
            r_seed_third  <= SEED_THIRD_RST;
            r_busy        <= 1'b0;
            r_dirty       <= 1'b1;
            r_init        <= 1'b1;
            r_load        <= 1'b0;
        end else begin
            r_load <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SEED_FIRST:  r_seed_first  <= i_cfg_data;
                    CFG_SEED_SECOND: r_seed_second <= i_cfg_data;
                    CFG_SEED_THIRD:  r_seed_third  <= i_cfg_data;
                    default: ;
                endcase
            end
            // a write always asks for a fresh fill; an idle engine takes the request
            if (i_cfg_we) begin
                r_dirty <= 1'b1;
            end else if (!r_busy) begin
                r_dirty <= 1'b0;
            end
            if (r_busy) begin
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_load <= r_init;
                    r_init <= 1'b0;
                end
            end else if (r_dirty) begin
                r_busy <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_work        <= n_work;
            r_dice[r_cnt] <= n_die;
            r_total       <= r_total + TOTAL_W'(n_die);
            r_cnt         <= r_cnt + IDX_W'(1);
        end else if (r_dirty) begin
            r_work  <= '{a: r_seed_first, b: r_seed_second, c: r_seed_third};
            r_total <= '0;
            r_cnt   <= '0;
        end
    end

    assign o_stat.busy  = r_busy | r_dirty | r_load;
    assign o_stat.load  = r_load;
    assign o_prep_taus  = r_work;
    assign o_prep_dice  = r_dice;
    assign o_prep_total = r_total;

endmodule

`default_nettype wire

>>> hdl/pnoise_core.sv
// Live generator state and the per-tick datapath: two draws, die update, Q2.22 map.
// Depends on pnoise_pkg.
`default_nettype none

module pnoise_core
    import pnoise_pkg::*;
#(
    parameter int NUM_ROWS = ROWS_DEF
) (
    input  logic                i_clk,
    input  logic                i_accept,
    input  logic                i_reseed,
    input  t_fill_stat          i_stat,
    input  t_taus               i_prep_taus,
    input  logic [DIE_W-1:0]    i_prep_dice [NUM_ROWS],
    input  logic [TOTAL_W-1:0]  i_prep_total,
    output logic [SAMPLE_W-1:0] o_sample
);

    localparam int IDX_W = $clog2(NUM_ROWS);

    t_taus              r_taus;
    logic [DIE_W-1:0]   r_dice [NUM_ROWS];
    logic [TOTAL_W-1:0] r_total;

    t_taus              w_src_taus;
    logic [DIE_W-1:0]   w_src_dice [NUM_ROWS];
    logic [TOTAL_W-1:0] w_src_total;
    t_taus              w_st1;
    t_taus              w_st2;
    logic [TAUS_W-1:0]  w_r1;
    logic [TAUS_W-1:0]  w_r2;
    logic [DIE_W-1:0]   w_fresh;
    logic [DIE_W-1:0]   w_second;
    logic [IDX_W-1:0]   w_row [TAUS_W];
    logic [IDX_W-1:0]   w_k;
    logic [TOTAL_W-1:0] n_total;
    logic [DIE_W-1:0]   n_dice [NUM_ROWS];
    logic [SAMPLE_W-1:0] w_sum;

    // die index for each trailing-zero count, reduced modulo the row count
    for (genvar j = 0; j < TAUS_W; j++) begin : g_row
        assign w_row[j] = IDX_W'(j % NUM_ROWS);
    end

    // a reseed tick starts from the prepared fill instead of the live state
    assign w_src_taus  = i_reseed ? i_prep_taus  : r_taus;
    assign w_src_total = i_reseed ? i_prep_total : r_total;
    always_comb begin
        for (int i = 0; i < NUM_ROWS; i++) begin
            w_src_dice[i] = i_reseed ? i_prep_dice[i] : r_dice[i];
        end
    end

    assign w_st1    = taus_next(w_src_taus);
    assign w_r1     = taus_out(w_st1);
    assign w_fresh  = w_r1[TAUS_W-1:DIE_SHIFT];
    assign w_st2    = taus_next(w_st1);
    assign w_r2     = taus_out(w_st2);
    assign w_second = w_r2[TAUS_W-1:DIE_SHIFT];

    // lowest set bit wins; a zero draw selects row zero
    always_comb begin
        w_k = '0;
        for (int j = TAUS_W - 1; j >= 0; j--) begin
            if (w_r1[j]) begin
                w_k = w_row[j];
            end
        end
    end

    assign n_total = w_src_total + TOTAL_W'(w_fresh) - TOTAL_W'(w_src_dice[w_k]);

    always_comb begin
        for (int i = 0; i < NUM_ROWS; i++) begin
            n_dice[i] = (w_k == IDX_W'(i)) ? w_fresh : w_src_dice[i];
        end
    end

    assign w_sum = SAMPLE_W'(n_total) + SAMPLE_W'(w_second);

    always_comb begin
        if (!w_sum[SAMPLE_W-1]) begin
            o_sample = w_sum - Q_HALF;
        end else begin
            o_sample = {w_sum[SAMPLE_W-2:0], 1'b0} - Q_THREE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_stat.load) begin
            r_taus  <= i_prep_taus;
            r_dice  <= i_prep_dice;
            r_total <= i_prep_total;
        end else if (i_accept) begin
            r_taus  <= w_st2;
            r_dice  <= n_dice;
            r_total <= n_total;
        end
    end

endmodule

`default_nettype wire

>>> hdl/pnoise_skid.sv
// Two-entry result buffer: output register plus skid register.
// Depends on pnoise_pkg.
`default_nettype none

module pnoise_skid
    import pnoise_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [SAMPLE_W-1:0] i_data,
    output logic                o_full,
    output logic                o_valid,
    output logic [SAMPLE_W-1:0] o_data,
    input  logic                i_stall
);

    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_data;
    logic                r_skid_valid;
    logic [SAMPLE_W-1:0] r_skid_data;
    logic                w_pop;

    assign w_pop = r_out_valid & ~i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && !w_pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_out_data <= r_skid_data;
            end
        end else if (i_push) begin
            if (r_out_valid && !w_pop) begin
                r_skid_data <= i_data;
            end else begin
                r_out_data <= i_data;
            end
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

`default_nettype wire

>>> hdl/pink_noise_generator_unit.sv
// Top level of the Voss-McCartney pink noise generator.
// Depends on pnoise_pkg, pnoise_fill, pnoise_core and pnoise_skid.
//
//   channel   direction  handshake                   payload
//   input     in         i_in_valid / o_in_stall     i_reseed (1 bit)
//   output    out        o_out_valid / i_out_stall   o_sample (24 bit signed, Q2.22)
//   config    in         i_cfg_we                    i_cfg_index (2), i_cfg_data (32)
//
// One tick beat is accepted per clock while the input is not stalled; its sample
// is registered at the accepting edge, in the output register or, if that still
// holds an untaken beat, in the skid register. The two draws, the die update and
// the Q2.22 map are one combinational pass over the live state registers.
// After reset the fill engine draws the dice at one row per cycle while the input
// stalls; any configuration write starts a fresh fill, stalling the input until it
// ends, so a reseed beat always finds a finished set. A skid register absorbs output
// stalls; else the input stalls only once the output and skid registers hold a beat.
`default_nettype none

module pink_noise_generator_unit
    import pnoise_pkg::*;
#(
    parameter int NUM_ROWS = ROWS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [TAUS_W-1:0]          i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_reseed,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_sample
);

    t_fill_stat          w_stat;
    t_taus               w_prep_taus;
    logic [DIE_W-1:0]    w_prep_dice [NUM_ROWS];
    logic [TOTAL_W-1:0]  w_prep_total;
    logic [SAMPLE_W-1:0] w_sample;
    logic [SAMPLE_W-1:0] w_out_data;
    logic                w_full;
    logic                w_accept;

    // hold the input while the fill runs or both result slots are taken
    assign o_in_stall = w_stat.busy | w_full;
    assign w_accept   = i_in_valid & ~o_in_stall;

    pnoise_fill #(
        .NUM_ROWS(NUM_ROWS)
    ) u_fill (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_stat       (w_stat),
        .o_prep_taus  (w_prep_taus),
        .o_prep_dice  (w_prep_dice),
        .o_prep_total (w_prep_total)
    );

    pnoise_core #(
        .NUM_ROWS(NUM_ROWS)
    ) u_core (
        .i_clk        (i_clk),
        .i_accept     (w_accept),
        .i_reseed     (i_reseed),
        .i_stat       (w_stat),
        .i_prep_taus  (w_prep_taus),
        .i_prep_dice  (w_prep_dice),
        .i_prep_total (w_prep_total),
        .o_sample     (w_sample)
    );

    pnoise_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_sample),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .o_data  (w_out_data),
        .i_stall (i_out_stall)
    );

    assign o_sample = $signed(w_out_data);

endmodule

`default_nettype wire

>>> hdl/pnoise_check.sv
// Port-level checks for the pink noise generator, bound to the top level.
// Depends on pnoise_pkg.
`default_nettype none

module pnoise_check
    import pnoise_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic signed [SAMPLE_W-1:0] o_sample
);

    // the dice fill holds off input right after reset
    a_fill_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not held after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sample))
        else $error("stalled output beat changed");

    a_accept_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !o_out_valid |=> o_out_valid)
        else $error("accepted beat did not reach the empty output");

    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_sample >= -24'sd4194304 && o_sample <= 24'sd5242846)
        else $error("sample out of range");

endmodule

bind pink_noise_generator_unit pnoise_check u_check (.*);

`default_nettype wire

>>> tb/testbench.sv
// Self-checking bench for pink_noise_generator_unit: drives tick beats with and without
// reseed, rewrites the seed registers between phases and checks every sample beat.
// Depends on pnoise_pkg and the RTL under hdl/.
`default_nettype none

module testbench;
    import pnoise_pkg::*;

    // Index past the three seed registers; the block must ignore writes to it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int HALF_LSB = 1 << 22;   // 2^22 in sample units
    localparam int SETTLE_CYCLES = 20;   // drain time after the last expected beat
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_TICKS = 55;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = CFG_SEED_FIRST;
    logic [TAUS_W-1:0]          i_cfg_data  = '0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_stall;
    logic                       i_reseed    = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] o_sample;

    pink_noise_generator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_reseed    (i_reseed),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_sample    (o_sample)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: seed registers, live generator words, dice and total
    // ------------------------------------------------------------------
    logic [TAUS_W-1:0]  seed_a, seed_b, seed_c;
    logic [TAUS_W-1:0]  gen_a, gen_b, gen_c;
    logic [DIE_W-1:0]   dice [ROWS_DEF];
    logic [TOTAL_W-1:0] dice_sum;

    logic signed [SAMPLE_W-1:0] sample_q [$];   // samples still owed by the block
    logic signed [SAMPLE_W-1:0] want;
    int errors = 0;
    bit bursty = 1'b1;                           // random idling on both sides
    int out_hold = 0;

    // Advance the three Tausworthe words once and return the combined draw
    function automatic logic [TAUS_W-1:0] taus_draw();
        logic [TAUS_W-1:0] t;
        t     = ((gen_a << 13) ^ gen_a) >> 19;
        gen_a = ((gen_a & 32'hFFFF_FFFE) << 12) ^ t;
        t     = ((gen_b << 2) ^ gen_b) >> 25;
        gen_b = ((gen_b & 32'hFFFF_FFF8) << 4) ^ t;
        t     = ((gen_c << 3) ^ gen_c) >> 11;
        gen_c = ((gen_c & 32'hFFFF_FFF0) << 17) ^ t;
        return gen_a ^ gen_b ^ gen_c;
    endfunction

    // Load the seed registers into the generator and redraw every die
    function automatic void refill_dice();
        logic [TAUS_W-1:0] r;
        gen_a    = seed_a;
        gen_b    = seed_b;
        gen_c    = seed_c;
        dice_sum = '0;
        for (int i = 0; i < ROWS_DEF; i++) begin
            r        = taus_draw();
            dice[i]  = r[TAUS_W-1:DIE_SHIFT];
            dice_sum = dice_sum + TOTAL_W'(dice[i]);
        end
    endfunction

    function automatic void reset_noise_model();
        seed_a = SEED_FIRST_RST;
        seed_b = SEED_SECOND_RST;
        seed_c = SEED_THIRD_RST;
        refill_dice();
    endfunction

    // Work out the sample of one tick beat and advance the generator
    function automatic logic signed [SAMPLE_W-1:0] next_pink_sample(input logic reseed);
        logic [TAUS_W-1:0] r;
        logic [DIE_W-1:0]  fresh;
        logic [TAUS_W-1:0] s;
        int unsigned       k;
        int                val;
        if (reseed)
            refill_dice();
        r = taus_draw();
        // trailing-zero count picks the die; a zero draw picks die 0
        k = 0;
        if (r != '0)
            while (r[k] == 1'b0)
                k++;
        k        = k % ROWS_DEF;
        fresh    = r[TAUS_W-1:DIE_SHIFT];
        dice_sum = dice_sum + TOTAL_W'(fresh) - TOTAL_W'(dice[k]);
        dice[k]  = fresh;
        r        = taus_draw();
        s        = {{(TAUS_W-TOTAL_W){1'b0}}, dice_sum} + (r >> DIE_SHIFT);
        // exact fixed-point form of the float bit trick
        if (s < 32'h0080_0000)
            val = int'(s) - HALF_LSB;
        else
            val = 2 * int'(s) - 3 * HALF_LSB;
        return val[SAMPLE_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stall bursts, and the check of every sample beat
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (out_hold != 0) begin
            out_hold--;
            i_out_stall <= 1'b1;
        end else if (bursty && i_rst_n && $urandom_range(0, 5) == 0) begin
            out_hold = $urandom_range(0, 2);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (sample_q.size() == 0) begin
                $error("sample: expected nothing, actual %0d", o_sample);
                errors++;
            end else begin
                want = sample_q.pop_front();
                if (o_sample !== want) begin
                    $error("sample: expected %0d, actual %0d", want, o_sample);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers; every task starts and ends just after a falling edge
    // ------------------------------------------------------------------

    // Offer one tick beat, hold it until accepted, then record its sample
    task automatic send_tick(input logic reseed);
        if (bursty && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_reseed   <= reseed;
        do
            @(posedge i_clk);
        while (o_in_stall);
        sample_q.push_back(next_pink_sample(reseed));
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every owed sample has come out
    task automatic drain_samples();
        i_in_valid <= 1'b0;
        do
            @(negedge i_clk);
        while (sample_q.size() != 0);
    endtask

    // Write one register; call only while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TAUS_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SEED_FIRST:  seed_a = data;
            CFG_SEED_SECOND: seed_b = data;
            CFG_SEED_THIRD:  seed_c = data;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic load_seeds(input logic [TAUS_W-1:0] a, b, c);
        drain_samples();
        write_reg(CFG_SEED_FIRST, a);
        write_reg(CFG_SEED_SECOND, b);
        write_reg(CFG_SEED_THIRD, c);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Plain ticks straight out of reset use the dice drawn from the reset seeds
    task automatic test_after_reset();
        repeat (4) send_tick(1'b0);
    endtask

    // Reseed with the reset seeds, twice back to back, then plain ticks
    task automatic test_reseed_reset_seeds();
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
    endtask

    // New seeds must not touch the live state until a reseed beat
    task automatic test_seed_extremes();
        load_seeds(32'd2, 32'd8, 32'd16);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        load_seeds(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
    endtask

    // Seeds below their minimum: all zero gives zero draws, so die 0 is hit
    // every time; a write past the last register changes nothing
    task automatic test_degenerate_seeds();
        load_seeds(32'd0, 32'd0, 32'd0);
        repeat (3) send_tick(1'b1 ^ (sample_q.size() != 0));
        send_tick(1'b0);
        load_seeds(32'd1, 32'd7, 32'd15);
        send_tick(1'b1);
        send_tick(1'b0);
        drain_samples();
        write_reg(CFG_UNUSED, 32'hA5A5_5A5A);
        send_tick(1'b1);
        send_tick(1'b0);
    endtask

    // Phases of random seeds followed by runs of ticks with occasional reseeds
    task automatic test_random_ticks();
        logic [TAUS_W-1:0] sa, sb, sc;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            // one quiet stretch in the middle, none at all near the end
            bursty = (phase != 3) && (phase < RANDOM_PHASES - 2);
            case ($urandom_range(0, 4))
                0: begin
                    sa = $urandom_range(0, 31);
                    sb = $urandom_range(0, 31);
                    sc = $urandom_range(0, 31);
                end
                1: begin
                    sa = 32'hFFFF_FFFF - $urandom_range(0, 3);
                    sb = 32'hFFFF_FFFF - $urandom_range(0, 3);
                    sc = 32'hFFFF_FFFF - $urandom_range(0, 3);
                end
                default: begin
                    sa = $urandom;
                    sb = $urandom;
                    sc = $urandom;
                end
            endcase
            load_seeds(sa, sb, sc);
            if ($urandom_range(0, 1) == 1)
                write_reg(CFG_UNUSED, $urandom);
            // half the phases run on the old state for a while before reseeding
            send_tick(1'($urandom_range(0, 1)));
            repeat (PHASE_TICKS) send_tick($urandom_range(0, 9) == 0);
        end
    endtask

    initial begin
        reset_noise_model();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_reseed_reset_seeds();
        test_seed_extremes();
        test_degenerate_seeds();
        test_random_ticks();

        drain_samples();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (errors == 0 && sample_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #200000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
hdl/pnoise_pkg.sv
hdl/pnoise_fill.sv
hdl/pnoise_core.sv
hdl/pnoise_skid.sv
hdl/pink_noise_generator_unit.sv
hdl/pnoise_check.sv
tb/testbench.sv
